### hw/rtl/plfd_pkg.sv
// Shared constants for the point to line foot and distance pipeline.
package plfd_pkg;

  // Register stages ahead of the divider: differences, products, sums,
  // split products, product merge.
  localparam int unsigned PRE_STAGES = 5;
  // Register stages between divider and square root plus the output:
  // foot and clamp, squares, sum of squares, output register.
  localparam int unsigned POST_STAGES = 4;

endpackage

### hw/rtl/point_line_foot_distance.sv
// Point to line perpendicular foot and distance, fully pipelined.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  input   | in_point_*, in_start_*, in_end_*        | start high and busy low
//  result  | out_foot_*, out_distance, out_degenerate,| out_valid high for one cycle
//          | out_overflow                            |
//
// One transaction enters per clock; busy stays low, nothing ever waits.
// The quotient takes COORD_WIDTH+1 one-bit divider stages, the root
// COORD_WIDTH+1 one-bit root stages.
// The result register cannot be held off; every stage advances each cycle.
// rst_n (synchronous) clears only the valid bits; payload flows unreset.
module point_line_foot_distance #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_foot_x,
  output logic signed [COORD_WIDTH-1:0] out_foot_y,
  output logic        [COORD_WIDTH:0]   out_distance,
  output logic                          out_degenerate,
  output logic                          out_overflow
);
  import plfd_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int MW  = 2 * W + 1;    // dot product magnitude
  localparam int DNW = 2 * W + 1;    // squared line length
  localparam int HW  = W + 1;        // low slice of the dot product
  localparam int PW  = MW + W;       // dividend magnitude
  localparam int RW  = PW + 1;       // divider remainder
  localparam int QW  = W + 1;        // quotient bits
  localparam int SRW = W + 1;        // root bits
  localparam int TW  = 2 * W + 3;    // root remainder
  localparam int LAT = PRE_STAGES + QW + SRW + POST_STAGES;

  localparam logic signed [W+1:0] CMAX = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] CMIN = {3'b111, {(W-1){1'b0}}};

  logic in_fire;
  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  // ---------------- stage A: differences ----------------
  logic                a_v_r;
  logic signed [W:0]   a_dx_r, a_dy_r, a_ax_r, a_ay_r;
  logic signed [W-1:0] a_px_r, a_py_r, a_sx_r, a_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else        a_v_r <= in_fire;
  end

  always_ff @(posedge clk) begin
    a_dx_r <= {in_start_x[W-1], in_start_x} - {in_end_x[W-1], in_end_x};
    a_dy_r <= {in_start_y[W-1], in_start_y} - {in_end_y[W-1], in_end_y};
    a_ax_r <= {in_point_x[W-1], in_point_x} - {in_start_x[W-1], in_start_x};
    a_ay_r <= {in_point_y[W-1], in_point_y} - {in_start_y[W-1], in_start_y};
    a_px_r <= in_point_x;
    a_py_r <= in_point_y;
    a_sx_r <= in_start_x;
    a_sy_r <= in_start_y;
  end

  // ---------------- stage B: products ----------------
  logic                  b_v_r;
  logic signed [2*W+1:0] b_mx_r, b_my_r, b_dxx_r, b_dyy_r;
  logic signed [W:0]     b_dx_r, b_dy_r;
  logic signed [W-1:0]   b_px_r, b_py_r, b_sx_r, b_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else        b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    b_mx_r  <= a_ax_r * a_dx_r;
    b_my_r  <= a_ay_r * a_dy_r;
    b_dxx_r <= a_dx_r * a_dx_r;
    b_dyy_r <= a_dy_r * a_dy_r;
    b_dx_r  <= a_dx_r;
    b_dy_r  <= a_dy_r;
    b_px_r  <= a_px_r;
    b_py_r  <= a_py_r;
    b_sx_r  <= a_sx_r;
    b_sy_r  <= a_sy_r;
  end

  // ---------------- stage C: dot product, length, magnitudes ----------------
  logic signed [2*W+1:0] c_num;
  logic signed [W:0]     c_dxa, c_dya;
  logic                  c_v_r, c_nneg_r, c_dxneg_r, c_dyneg_r, c_degen_r;
  logic [MW-1:0]         c_nmag_r;
  logic [DNW-1:0]        c_den_r;
  logic [W-1:0]          c_dxm_r, c_dym_r;
  logic signed [W-1:0]   c_px_r, c_py_r, c_sx_r, c_sy_r;

  assign c_num = b_mx_r + b_my_r;
  assign c_dxa = b_dx_r[W] ? -b_dx_r : b_dx_r;
  assign c_dya = b_dy_r[W] ? -b_dy_r : b_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else        c_v_r <= b_v_r;
  end

  always_ff @(posedge clk) begin
    c_nneg_r  <= c_num[2*W+1];
    c_nmag_r  <= c_num[2*W+1] ? MW'(-c_num) : c_num[MW-1:0];
    c_den_r   <= b_dxx_r[DNW-1:0] + b_dyy_r[DNW-1:0];
    c_degen_r <= (b_dx_r == '0) && (b_dy_r == '0);
    c_dxneg_r <= b_dx_r[W];
    c_dyneg_r <= b_dy_r[W];
    c_dxm_r   <= c_dxa[W-1:0];
    c_dym_r   <= c_dya[W-1:0];
    c_px_r    <= b_px_r;
    c_py_r    <= b_py_r;
    c_sx_r    <= b_sx_r;
    c_sy_r    <= b_sy_r;
  end

  // ---------------- stage D: split dividend products ----------------
  logic                d_v_r, d_negx_r, d_negy_r, d_degen_r;
  logic [2*W:0]        d_pxl_r, d_pyl_r;
  logic [2*W-1:0]      d_pxh_r, d_pyh_r;
  logic [DNW-1:0]      d_den_r;
  logic signed [W-1:0] d_px_r, d_py_r, d_sx_r, d_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else        d_v_r <= c_v_r;
  end

  always_ff @(posedge clk) begin
    d_pxl_r   <= c_nmag_r[HW-1:0] * c_dxm_r;
    d_pyl_r   <= c_nmag_r[HW-1:0] * c_dym_r;
    d_pxh_r   <= c_nmag_r[MW-1:HW] * c_dxm_r;
    d_pyh_r   <= c_nmag_r[MW-1:HW] * c_dym_r;
    d_negx_r  <= c_nneg_r ^ c_dxneg_r;
    d_negy_r  <= c_nneg_r ^ c_dyneg_r;
    d_den_r   <= c_den_r;
    d_degen_r <= c_degen_r;
    d_px_r    <= c_px_r;
    d_py_r    <= c_py_r;
    d_sx_r    <= c_sx_r;
    d_sy_r    <= c_sy_r;
  end

  // ---------------- stage E and divider pipeline ----------------
  // Index 0 holds the merged dividend; stage k resolves quotient bit QW-1-k.
  logic                v_dv_r    [0:QW];
  logic [RW-1:0]       remx_r    [0:QW];
  logic [RW-1:0]       remy_r    [0:QW];
  logic [QW-1:0]       qx_r      [0:QW];
  logic [QW-1:0]       qy_r      [0:QW];
  logic [DNW-1:0]      dv_den_r  [0:QW];
  logic                dv_negx_r [0:QW];
  logic                dv_negy_r [0:QW];
  logic                dv_deg_r  [0:QW];
  logic signed [W-1:0] dv_px_r   [0:QW];
  logic signed [W-1:0] dv_py_r   [0:QW];
  logic signed [W-1:0] dv_sx_r   [0:QW];
  logic signed [W-1:0] dv_sy_r   [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) v_dv_r[0] <= 1'b0;
    else        v_dv_r[0] <= d_v_r;
  end

  always_ff @(posedge clk) begin
    remx_r[0]    <= RW'(d_pxl_r) + (RW'(d_pxh_r) << HW);
    remy_r[0]    <= RW'(d_pyl_r) + (RW'(d_pyh_r) << HW);
    qx_r[0]      <= '0;
    qy_r[0]      <= '0;
    dv_den_r[0]  <= d_den_r;
    dv_negx_r[0] <= d_negx_r;
    dv_negy_r[0] <= d_negy_r;
    dv_deg_r[0]  <= d_degen_r;
    dv_px_r[0]   <= d_px_r;
    dv_py_r[0]   <= d_py_r;
    dv_sx_r[0]   <= d_sx_r;
    dv_sy_r[0]   <= d_sy_r;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int BIT = QW - 1 - k;
    logic [RW-1:0] dsh;
    logic          gex, gey;

    // shifted divisor, compare and subtract per coordinate
    assign dsh = RW'(dv_den_r[k]) << BIT;
    assign gex = remx_r[k] >= dsh;
    assign gey = remy_r[k] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) v_dv_r[k+1] <= 1'b0;
      else        v_dv_r[k+1] <= v_dv_r[k];
    end

    always_ff @(posedge clk) begin
      remx_r[k+1]    <= gex ? remx_r[k] - dsh : remx_r[k];
      remy_r[k+1]    <= gey ? remy_r[k] - dsh : remy_r[k];
      qx_r[k+1]      <= qx_r[k] | (QW'(gex) << BIT);
      qy_r[k+1]      <= qy_r[k] | (QW'(gey) << BIT);
      dv_den_r[k+1]  <= dv_den_r[k];
      dv_negx_r[k+1] <= dv_negx_r[k];
      dv_negy_r[k+1] <= dv_negy_r[k];
      dv_deg_r[k+1]  <= dv_deg_r[k];
      dv_px_r[k+1]   <= dv_px_r[k];
      dv_py_r[k+1]   <= dv_py_r[k];
      dv_sx_r[k+1]   <= dv_sx_r[k];
      dv_sy_r[k+1]   <= dv_sy_r[k];
    end
  end

  // ---------------- stage F: foot, clamp, degenerate override ----------------
  logic signed [W+1:0] f_sxe, f_sye, f_qxe, f_qye, f_fx, f_fy;
  logic                f_ovx, f_ovy;
  logic signed [W-1:0] f_cx, f_cy;
  logic                f_v_r, f_ovf_r, f_deg_r;
  logic signed [W-1:0] f_fx_r, f_fy_r, f_px_r, f_py_r;

  assign f_sxe = {{2{dv_sx_r[QW][W-1]}}, dv_sx_r[QW]};
  assign f_sye = {{2{dv_sy_r[QW][W-1]}}, dv_sy_r[QW]};
  assign f_qxe = {1'b0, qx_r[QW]};
  assign f_qye = {1'b0, qy_r[QW]};
  assign f_fx  = dv_negx_r[QW] ? f_sxe - f_qxe : f_sxe + f_qxe;
  assign f_fy  = dv_negy_r[QW] ? f_sye - f_qye : f_sye + f_qye;
  assign f_ovx = (f_fx > CMAX) || (f_fx < CMIN);
  assign f_ovy = (f_fy > CMAX) || (f_fy < CMIN);
  assign f_cx  = (f_fx > CMAX) ? CMAX[W-1:0] : (f_fx < CMIN) ? CMIN[W-1:0] : f_fx[W-1:0];
  assign f_cy  = (f_fy > CMAX) ? CMAX[W-1:0] : (f_fy < CMIN) ? CMIN[W-1:0] : f_fy[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else        f_v_r <= v_dv_r[QW];
  end

  always_ff @(posedge clk) begin
    f_deg_r <= dv_deg_r[QW];
    f_ovf_r <= ~dv_deg_r[QW] & (f_ovx | f_ovy);
    f_fx_r  <= dv_deg_r[QW] ? dv_sx_r[QW] : f_cx;
    f_fy_r  <= dv_deg_r[QW] ? dv_sy_r[QW] : f_cy;
    f_px_r  <= dv_px_r[QW];
    f_py_r  <= dv_py_r[QW];
  end

  // ---------------- stage G: squared offsets ----------------
  logic signed [W:0]     g_ex, g_ey;
  logic signed [2*W+1:0] g_sqx, g_sqy;
  logic                  g_v_r, g_ovf_r, g_deg_r;
  logic [2*W-1:0]        g_sqx_r, g_sqy_r;
  logic signed [W-1:0]   g_fx_r, g_fy_r;

  assign g_ex  = {f_px_r[W-1], f_px_r} - {f_fx_r[W-1], f_fx_r};
  assign g_ey  = {f_py_r[W-1], f_py_r} - {f_fy_r[W-1], f_fy_r};
  assign g_sqx = g_ex * g_ex;
  assign g_sqy = g_ey * g_ey;

  always_ff @(posedge clk) begin
    if (!rst_n) g_v_r <= 1'b0;
    else        g_v_r <= f_v_r;
  end

  always_ff @(posedge clk) begin
    g_sqx_r <= g_sqx[2*W-1:0];
    g_sqy_r <= g_sqy[2*W-1:0];
    g_ovf_r <= f_ovf_r;
    g_deg_r <= f_deg_r;
    g_fx_r  <= f_fx_r;
    g_fy_r  <= f_fy_r;
  end

  // ---------------- stage H and root pipeline ----------------
  // Stage k resolves root bit W-k on the running remainder n - r*r.
  logic                v_sr_r   [0:SRW];
  logic [TW-1:0]       srem_r   [0:SRW];
  logic [SRW-1:0]      root_r   [0:SRW];
  logic                sr_ovf_r [0:SRW];
  logic                sr_deg_r [0:SRW];
  logic signed [W-1:0] sr_fx_r  [0:SRW];
  logic signed [W-1:0] sr_fy_r  [0:SRW];

  always_ff @(posedge clk) begin
    if (!rst_n) v_sr_r[0] <= 1'b0;
    else        v_sr_r[0] <= g_v_r;
  end

  always_ff @(posedge clk) begin
    srem_r[0]   <= TW'(g_sqx_r) + TW'(g_sqy_r);
    root_r[0]   <= '0;
    sr_ovf_r[0] <= g_ovf_r;
    sr_deg_r[0] <= g_deg_r;
    sr_fx_r[0]  <= g_fx_r;
    sr_fy_r[0]  <= g_fy_r;
  end

  for (genvar k = 0; k < SRW; k++) begin : g_root
    localparam int BIT = SRW - 1 - k;
    logic [TW-1:0] trial;
    logic          take;

    // (r + 2^b)^2 - r^2, the bits never overlap
    assign trial = (TW'(root_r[k]) << (BIT + 1)) | (TW'(1'b1) << (2 * BIT));
    assign take  = srem_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) v_sr_r[k+1] <= 1'b0;
      else        v_sr_r[k+1] <= v_sr_r[k];
    end

    always_ff @(posedge clk) begin
      srem_r[k+1]   <= take ? srem_r[k] - trial : srem_r[k];
      root_r[k+1]   <= root_r[k] | (SRW'(take) << BIT);
      sr_ovf_r[k+1] <= sr_ovf_r[k];
      sr_deg_r[k+1] <= sr_deg_r[k];
      sr_fx_r[k+1]  <= sr_fx_r[k];
      sr_fy_r[k+1]  <= sr_fy_r[k];
    end
  end

  // ---------------- output register ----------------
  logic                o_v_r, o_ovf_r, o_deg_r;
  logic [SRW-1:0]      o_dist_r;
  logic signed [W-1:0] o_fx_r, o_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else        o_v_r <= v_sr_r[SRW];
  end

  always_ff @(posedge clk) begin
    o_dist_r <= root_r[SRW];
    o_ovf_r  <= sr_ovf_r[SRW];
    o_deg_r  <= sr_deg_r[SRW];
    o_fx_r   <= sr_fx_r[SRW];
    o_fy_r   <= sr_fy_r[SRW];
  end

  assign out_valid      = o_v_r;
  assign out_foot_x     = o_fx_r;
  assign out_foot_y     = o_fy_r;
  assign out_distance   = o_dist_r;
  assign out_degenerate = o_deg_r;
  assign out_overflow   = o_ovf_r;

  // ---------------- checks ----------------
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, LAT))
    else $error("result strobe without a transaction at fixed latency");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_fire, LAT) && $past(rst_n, LAT) |-> out_valid)
    else $error("accepted transaction produced no result");

  a_deg_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> !out_overflow)
    else $error("degenerate line flagged overflow");

  a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
    v_sr_r[SRW] |-> srem_r[SRW] <= (TW'(root_r[SRW]) << 1))
    else $error("root remainder out of range");

endmodule

### bench/tb_point_line_foot_distance.sv
// Testbench for the point to line perpendicular foot and distance pipeline.
module tb_point_line_foot_distance;

  localparam int CW = 24;
  // Pipeline depth of the block, from its stage counts.
  localparam int PIPE_DEPTH = 2 * CW + 11;
  localparam int RANDOM_ITEMS = 650;

  typedef struct {
    logic signed [CW-1:0] px, py, sx, sy, ex, ey;
  } line_query_t;

  typedef struct {
    logic signed [CW-1:0] foot_x, foot_y;
    logic        [CW:0]   distance;
    logic                 degen, ovf;
  } foot_result_t;

  // Predicts the foot and distance and keeps the expected results in order.
  class foot_scoreboard;
    foot_result_t pending_feet[$];
    int errors = 0;

    function automatic foot_result_t project(line_query_t q);
      logic signed [127:0] px, py, sx, sy, dx, dy, num, den, fx, fy, cmax, cmin;
      logic        [127:0] sq, root, cand;
      foot_result_t r;
      px = q.px; py = q.py; sx = q.sx; sy = q.sy;
      dx = sx - 128'(signed'(q.ex));
      dy = sy - 128'(signed'(q.ey));
      cmax = (128'sd1 <<< (CW - 1)) - 1;
      cmin = -cmax - 1;
      r.degen = (dx == 0 && dy == 0);
      r.ovf = 1'b0;
      if (r.degen) begin
        fx = sx;
        fy = sy;
      end else begin
        num = (px - sx) * dx + (py - sy) * dy;
        den = dx * dx + dy * dy;
        // signed division truncates toward zero
        fx = sx + (num * dx) / den;
        fy = sy + (num * dy) / den;
        if (fx > cmax) begin fx = cmax; r.ovf = 1'b1; end
        if (fx < cmin) begin fx = cmin; r.ovf = 1'b1; end
        if (fy > cmax) begin fy = cmax; r.ovf = 1'b1; end
        if (fy < cmin) begin fy = cmin; r.ovf = 1'b1; end
      end
      sq = (px - fx) * (px - fx) + (py - fy) * (py - fy);
      // floored square root, one bit at a time
      root = '0;
      for (int b = 35; b >= 0; b--) begin
        cand = root | (128'd1 << b);
        if (cand * cand <= sq) root = cand;
      end
      r.foot_x = fx[CW-1:0];
      r.foot_y = fy[CW-1:0];
      r.distance = root[CW:0];
      return r;
    endfunction

    function void note_query(line_query_t q);
      pending_feet.push_back(project(q));
    endfunction

    function void check_foot(foot_result_t act);
      foot_result_t exp_r;
      if (pending_feet.size() == 0) begin
        $display("%0t: unexpected result foot=(%0d,%0d) dist=%0d", $time,
                 act.foot_x, act.foot_y, act.distance);
        errors++;
        return;
      end
      exp_r = pending_feet.pop_front();
      if (act.foot_x !== exp_r.foot_x) begin
        $display("%0t: foot_x expected %0d actual %0d", $time, exp_r.foot_x, act.foot_x);
        errors++;
      end
      if (act.foot_y !== exp_r.foot_y) begin
        $display("%0t: foot_y expected %0d actual %0d", $time, exp_r.foot_y, act.foot_y);
        errors++;
      end
      if (act.distance !== exp_r.distance) begin
        $display("%0t: distance expected %0d actual %0d", $time, exp_r.distance,
                 act.distance);
        errors++;
      end
      if (act.degen !== exp_r.degen) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, exp_r.degen, act.degen);
        errors++;
      end
      if (act.ovf !== exp_r.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, exp_r.ovf, act.ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_point_x = '0, in_point_y = '0, in_start_x = '0;
  logic signed [CW-1:0] in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic out_valid;
  logic signed [CW-1:0] out_foot_x, out_foot_y;
  logic [CW:0] out_distance;
  logic out_degenerate, out_overflow;

  foot_scoreboard sb = new();

  point_line_foot_distance #(.COORD_WIDTH(CW)) dut (
    .clk, .rst_n, .start, .busy,
    .in_point_x, .in_point_y, .in_start_x, .in_start_y, .in_end_x, .in_end_y,
    .out_valid, .out_foot_x, .out_foot_y, .out_distance, .out_degenerate,
    .out_overflow
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Accepted transactions on both channels
  always @(posedge clk) begin
    foot_result_t act;
    if (rst_n && start && !busy)
      sb.note_query('{in_point_x, in_point_y, in_start_x, in_start_y, in_end_x, in_end_y});
    if (rst_n && out_valid) begin
      act.foot_x = out_foot_x;
      act.foot_y = out_foot_y;
      act.distance = out_distance;
      act.degen = out_degenerate;
      act.ovf = out_overflow;
      sb.check_foot(act);
    end
  end

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  task automatic send_query(line_query_t q);
    start <= 1'b1;
    in_point_x <= q.px; in_point_y <= q.py;
    in_start_x <= q.sx; in_start_y <= q.sy;
    in_end_x <= q.ex; in_end_y <= q.ey;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($urandom_range(2048) - 1024);
      default: return $urandom_range(1) ? CMAX - CW'($urandom_range(64))
                                        : CMIN + CW'($urandom_range(64));
    endcase
  endfunction

  function automatic line_query_t rand_query();
    line_query_t q;
    int mode;
    mode = $urandom_range(9);
    case (mode)
      0, 1, 2, 3: q = '{rand_coord(0), rand_coord(0), rand_coord(0),
                        rand_coord(0), rand_coord(0), rand_coord(0)};
      4, 5: q = '{rand_coord(1), rand_coord(1), rand_coord(1),
                  rand_coord(1), rand_coord(1), rand_coord(1)};
      6: begin
        // coinciding line points
        q = '{rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0), '0, '0};
        q.ex = q.sx;
        q.ey = q.sy;
      end
      7: q = '{rand_coord(2), rand_coord(2), rand_coord(2),
               rand_coord(2), rand_coord(2), rand_coord(2)};
      default: begin
        // short line near the edge, far point: pushes the foot out of range
        q.sx = rand_coord(2); q.sy = rand_coord(2);
        q.ex = q.sx + CW'($urandom_range(6)) - CW'(3);
        q.ey = q.sy + CW'($urandom_range(6)) - CW'(3);
        q.px = rand_coord(0); q.py = rand_coord(0);
      end
    endcase
    return q;
  endfunction

  // Stimulus
  initial begin
    line_query_t directed[$];
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
    directed.push_back('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN});
    directed.push_back('{CMAX, CMIN, CMIN, CMAX, CMAX, CMIN});
    directed.push_back('{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX});
    directed.push_back('{CMAX, CMAX, 24'sd0, 24'sd0, 24'sd0, 24'sd0});
    directed.push_back('{CMIN, CMIN, CMAX, CMAX, CMAX, CMAX});
    directed.push_back('{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0});
    directed.push_back('{24'sd512, 24'sd256, 24'sd0, 24'sd0, 24'sd256, 24'sd0});
    directed.push_back('{24'sd300, -24'sd700, 24'sd0, 24'sd0, 24'sd0, 24'sd256});
    directed.push_back('{24'sd1000, 24'sd7, 24'sd0, 24'sd0, 24'sd3, 24'sd1});
    directed.push_back('{CMIN, CMAX, CMAX, CMAX, CMAX - 24'sd1, CMAX - 24'sd2});
    directed.push_back('{CMAX, CMIN, CMIN, CMIN, CMIN + 24'sd1, CMIN + 24'sd2});
    directed.push_back('{CMIN, CMIN, CMAX, 24'sd0, CMAX - 24'sd1, -24'sd1});
    directed.push_back('{CMAX, CMAX, CMIN, 24'sd0, CMIN + 24'sd1, 24'sd1});
    directed.push_back('{CMAX, CMIN, CMAX, CMIN, CMIN, CMAX});
    directed.push_back('{-24'sd1, -24'sd1, 24'sd1, 24'sd1, -24'sd1, 24'sd1});
    foreach (directed[i]) send_query(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) begin
        // hold off until the pipeline has drained
        start <= 1'b0;
        while (sb.pending_feet.size() != 0) @(posedge clk);
      end
      // each cycle idles with odds 38 in 100, none in the busy stretch
      while ((n < 200 || n > 350) && $urandom_range(99) < 38)
        idle_cycles(1);
      send_query(rand_query());
    end
    start <= 1'b0;

    waited = 0;
    while (sb.pending_feet.size() != 0 && waited < 4 * PIPE_DEPTH) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_feet.size() == 0)
      $display("point_line_foot_distance: match");
    else
      $display("point_line_foot_distance: mismatch");
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("point_line_foot_distance: mismatch");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/plfd_pkg.sv
hw/rtl/point_line_foot_distance.sv
bench/tb_point_line_foot_distance.sv
